// ===== hw/rtl/playfair_pair_cipher_top_macros.svh =====
// Assertion macros for the Playfair pair cipher block.
`ifndef PLAYFAIR_PAIR_CIPHER_TOP_MACROS_SVH
`define PLAYFAIR_PAIR_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PLF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/plf_pkg.sv =====
// Shared types, constants and lookup functions of the Playfair pair cipher.
`default_nettype none
package plf_pkg;

	localparam int SIDE     = 5;
	localparam int LW       = 5;
	localparam int ROW_W    = SIDE * LW;
	localparam int IDX_W    = 3;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	typedef logic [LW-1:0]             letter_t;
	typedef logic [ROW_W-1:0]          row_t;
	typedef logic [SIDE-1:0][ROW_W-1:0] square_t;
	typedef logic [IDX_W-1:0]          idx_t;

	localparam letter_t LETTER_I    = letter_t'(8);
	localparam letter_t LETTER_J    = letter_t'(9);
	localparam letter_t LETTER_X    = letter_t'(23);
	localparam letter_t LETTER_Z    = letter_t'(25);
	localparam letter_t LAST_LETTER = letter_t'(25);

	localparam row_t ROW0_RST = row_t'(4294688);
	localparam row_t ROW1_RST = row_t'(10755269);
	localparam row_t ROW2_RST = row_t'(16201099);
	localparam row_t ROW3_RST = row_t'(21613104);
	localparam row_t ROW4_RST = row_t'(27025109);

	typedef enum logic [2:0] {
		REG_ROW0 = 3'd0,
		REG_ROW1 = 3'd1,
		REG_ROW2 = 3'd2,
		REG_ROW3 = 3'd3,
		REG_ROW4 = 3'd4,
		REG_DIR  = 3'd5
	} reg_idx_t;

	typedef enum logic {
		DIR_ENC = 1'b0,
		DIR_DEC = 1'b1
	} dir_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_ODD       = 2'd2
	} status_t;

	typedef enum logic {
		JOB_PAIR = 1'b0,
		JOB_ODD  = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		dir_t      dir;
		letter_t   first;
		letter_t   second;
	} job_t;

	typedef struct packed {
		logic found;
		idx_t row;
		idx_t col;
	} loc_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} q_stat_t;

	// Find a letter in the square; the first cell in row-major order wins.
	function automatic loc_t locate(square_t sq, letter_t l);
		loc_t res;
		res = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (l <= LAST_LETTER && sq[r][LW*c +: LW] == l) begin
					res.found = 1'b1;
					res.row   = idx_t'(r);
					res.col   = idx_t'(c);
				end
			end
		end
		return res;
	endfunction

	function automatic letter_t cell_at(square_t sq, idx_t r, idx_t c);
		letter_t res;
		res = '0;
		for (int rr = 0; rr < SIDE; rr++) begin
			for (int cc = 0; cc < SIDE; cc++) begin
				if (r == idx_t'(rr) && c == idx_t'(cc)) begin
					res = sq[rr][LW*cc +: LW];
				end
			end
		end
		return res;
	endfunction

	// Move one place with wrap: forward to encrypt, back to decrypt.
	function automatic idx_t step_idx(idx_t i, dir_t d);
		idx_t res;
		if (d == DIR_DEC) begin
			res = (i == '0) ? idx_t'(SIDE - 1) : idx_t'(i - 1'b1);
		end else begin
			res = (i == idx_t'(SIDE - 1)) ? '0 : idx_t'(i + 1'b1);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/plf_if.sv =====
// Valid/ready channel interfaces for letter beats and digram beats.
`default_nettype none
interface plf_in_if;
	import plf_pkg::*;
	logic    valid;
	logic    ready;
	logic    action;
	letter_t letter;

	modport source (output valid, output action, output letter, input ready);
	modport sink   (input valid, input action, input letter, output ready);
endinterface

interface plf_out_if;
	import plf_pkg::*;
	logic    valid;
	logic    ready;
	letter_t out_first;
	letter_t out_second;
	status_t status;

	modport source (output valid, output out_first, output out_second, output status,
		input ready);
	modport sink   (input valid, input out_first, input out_second, input status,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/plf_front.sv =====
// Front end: takes letter beats, pairs them into digram jobs.
`default_nettype none
module plf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	plf_in_if.sink              letter_ch,
	input  wire plf_pkg::dir_t  direction,
	input  wire logic           q_full,
	output logic                job_valid,
	output plf_pkg::job_t       job
);
	import plf_pkg::*;

	letter_t held_letter_q;
	logic    held_valid_q;
	letter_t letter_m;
	logic    accept;
	letter_t held_next;
	logic    held_valid_next;

	assign letter_ch.ready = !q_full;
	assign accept          = letter_ch.valid && letter_ch.ready;
	assign letter_m        = (letter_ch.letter == LETTER_J) ? LETTER_I : letter_ch.letter;

	always_comb begin
		job_valid       = 1'b0;
		job.kind        = JOB_PAIR;
		job.dir         = direction;
		job.first       = held_letter_q;
		job.second      = letter_m;
		held_next       = held_letter_q;
		held_valid_next = held_valid_q;
		if (letter_ch.action) begin
			// flush: pad or drop a lone letter
			if (held_valid_q) begin
				job_valid       = 1'b1;
				job.kind        = (direction == DIR_DEC) ? JOB_ODD : JOB_PAIR;
				job.second      = LETTER_Z;
				held_valid_next = 1'b0;
				held_next       = '0;
			end
		end else if (!held_valid_q) begin
			held_next       = letter_m;
			held_valid_next = 1'b1;
		end else if (direction == DIR_ENC && letter_m == held_letter_q) begin
			// doubled letter: split with x, keep the new copy held
			job_valid  = 1'b1;
			job.second = LETTER_X;
		end else begin
			job_valid       = 1'b1;
			held_valid_next = 1'b0;
			held_next       = '0;
		end
		if (!accept) begin
			job_valid       = 1'b0;
			held_next       = held_letter_q;
			held_valid_next = held_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
		end else begin
			held_letter_q <= held_next;
			held_valid_q  <= held_valid_next;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/plf_queue.sv =====
// Short job queue between the front end and the rewrite pipeline.
`default_nettype none
module plf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire plf_pkg::job_t  push_job,
	input  wire logic           pop_ready,
	output logic                head_valid,
	output plf_pkg::job_t       head_job,
	output plf_pkg::q_stat_t    stat
);
	import plf_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic              do_push;

	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign pop        = pop_ready && head_valid;
	assign do_push    = push && (count_q != QCNT_W'(QDEPTH));

	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
			end
			case ({do_push, pop})
				2'b10:   count_q <= QCNT_W'(count_q + 1'b1);
				2'b01:   count_q <= QCNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/plf_back.sv =====
// Back end: locates both letters, then rewrites the digram into the output register.
`default_nettype none
module plf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire plf_pkg::square_t square,
	input  wire logic             job_valid,
	input  wire plf_pkg::job_t    job,
	output logic                  job_ready,
	plf_out_if.source             digram_ch
);
	import plf_pkg::*;

	logic      valid_s1;
	job_kind_t kind_s1;
	dir_t      dir_s1;
	loc_t      loc_a_s1;
	loc_t      loc_b_s1;

	logic      out_valid_q;
	letter_t   out_first_q;
	letter_t   out_second_q;
	status_t   status_q;

	logic      load_out;
	letter_t   first_c;
	letter_t   second_c;
	status_t   status_c;

	assign load_out  = valid_s1 && (!out_valid_q || digram_ch.ready);
	assign job_ready = !valid_s1 || load_out;

	// Stage 1: parallel match of both letters over the 25 cells
	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			kind_s1  <= job.kind;
			dir_s1   <= job.dir;
			loc_a_s1 <= locate(square, job.first);
			loc_b_s1 <= locate(square, job.second);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (job_ready) begin
			valid_s1 <= job_valid;
		end
	end

	// Stage 2: same-row, same-column or rectangle rule
	always_comb begin
		first_c  = '0;
		second_c = '0;
		status_c = ST_OK;
		if (kind_s1 == JOB_ODD) begin
			status_c = ST_ODD;
		end else if (!(loc_a_s1.found && loc_b_s1.found)) begin
			status_c = ST_NOT_FOUND;
		end else if (loc_a_s1.row == loc_b_s1.row) begin
			first_c  = cell_at(square, loc_a_s1.row, step_idx(loc_a_s1.col, dir_s1));
			second_c = cell_at(square, loc_b_s1.row, step_idx(loc_b_s1.col, dir_s1));
		end else if (loc_a_s1.col == loc_b_s1.col) begin
			first_c  = cell_at(square, step_idx(loc_a_s1.row, dir_s1), loc_a_s1.col);
			second_c = cell_at(square, step_idx(loc_b_s1.row, dir_s1), loc_b_s1.col);
		end else begin
			first_c  = cell_at(square, loc_a_s1.row, loc_b_s1.col);
			second_c = cell_at(square, loc_b_s1.row, loc_a_s1.col);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_first_q  <= first_c;
			out_second_q <= second_c;
			status_q     <= status_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (digram_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign digram_ch.valid      = out_valid_q;
	assign digram_ch.out_first  = out_first_q;
	assign digram_ch.out_second = out_second_q;
	assign digram_ch.status     = status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/playfair_pair_cipher_top.sv =====
// Top level of the Playfair pair cipher: register file, front end, queue, back end.
// Usage:
//  - letter_ch carries one letter beat per handshake: action 0 is a letter
//    (a=0..z=25, j folds to i), action 1 flushes the end of a message.
//  - digram_ch carries one rewritten digram per beat, with a status code
//    (ok, letter not in square, odd ciphertext letter dropped).
//  - The APB port holds the five key square rows and the direction bit;
//    write them only while no message is in flight.
//  - Path: the beat that completes a digram goes through the queue write, the
//    letter match register and the rewrite into the output register to digram_ch.
//  - Throughput: one letter beat per cycle while the job queue is not full;
//    each digram passes once through the match stage and the rewrite stage.
//  - A stalled digram_ch holds its beat in the output register; the match
//    stage and a four-entry job queue keep taking letters until the queue
//    fills, then letter_ch.ready drops.
//  - Reset clears the held letter, the queue and all valids, and loads the
//    default square with direction set to encrypt.
`default_nettype none
`include "playfair_pair_cipher_top_macros.svh"
module playfair_pair_cipher_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	plf_in_if.sink                           letter_ch,
	plf_out_if.source                        digram_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [plf_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [plf_pkg::DATA_W-1:0]  pwdata,
	output logic      [plf_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);
	import plf_pkg::*;

	square_t  square_q;
	dir_t     direction_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic     job_push;
	job_t     job_in;
	logic     head_valid;
	job_t     head_job;
	logic     head_ready;
	q_stat_t  q_stat;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q[0] <= ROW0_RST;
			square_q[1] <= ROW1_RST;
			square_q[2] <= ROW2_RST;
			square_q[3] <= ROW3_RST;
			square_q[4] <= ROW4_RST;
			direction_q <= DIR_ENC;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ROW0: square_q[0] <= pwdata[ROW_W-1:0];
				REG_ROW1: square_q[1] <= pwdata[ROW_W-1:0];
				REG_ROW2: square_q[2] <= pwdata[ROW_W-1:0];
				REG_ROW3: square_q[3] <= pwdata[ROW_W-1:0];
				REG_ROW4: square_q[4] <= pwdata[ROW_W-1:0];
				REG_DIR:  direction_q <= dir_t'(pwdata[0]);
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ROW0: prdata = DATA_W'(square_q[0]);
			REG_ROW1: prdata = DATA_W'(square_q[1]);
			REG_ROW2: prdata = DATA_W'(square_q[2]);
			REG_ROW3: prdata = DATA_W'(square_q[3]);
			REG_ROW4: prdata = DATA_W'(square_q[4]);
			REG_DIR:  prdata = DATA_W'(direction_q);
			default:  prdata = '0;
		endcase
	end

	// Pair letters into jobs
	plf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.letter_ch (letter_ch),
		.direction (direction_q),
		.q_full    (q_stat.full),
		.job_valid (job_push),
		.job       (job_in)
	);

	// Decouple pairing from rewriting
	plf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job_in),
		.pop_ready  (head_ready),
		.head_valid (head_valid),
		.head_job   (head_job),
		.stat       (q_stat)
	);

	// Locate and rewrite
	plf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.square    (square_q),
		.job_valid (head_valid),
		.job       (head_job),
		.job_ready (head_ready),
		.digram_ch (digram_ch)
	);

	// Checks
	`PLF_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue count over depth")
	`PLF_ASSERT_NOW(a_no_push_full, job_push, !q_stat.full, "job pushed into a full queue")
	`PLF_ASSERT_NEXT(a_q_grow, job_push && !(head_valid && head_ready),
		q_stat.count == QCNT_W'($past(q_stat.count) + 1'b1), "queue lost a pushed job")
	`PLF_ASSERT_NOW(a_head_empty, q_stat.empty, !head_valid, "queue head valid while empty")
	`PLF_ASSERT_NOW(a_err_zero, digram_ch.valid && digram_ch.status != ST_OK,
		digram_ch.out_first == '0 && digram_ch.out_second == '0, "error beat with letters")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the Playfair pair cipher: letter stream in, checked digrams out.
`timescale 1ns / 100ps
module testbench;
	import plf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 150;
	// Margin after the last digram: pipeline latency plus slack.
	localparam int SETTLE_GAP  = 6;

	typedef struct packed {
		logic    flush;
		letter_t ltr;
	} letter_beat_t;

	typedef struct packed {
		letter_t first;
		letter_t second;
		status_t status;
	} digram_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	plf_in_if  letter_ch ();
	plf_out_if digram_ch ();

	playfair_pair_cipher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.letter_ch (letter_ch),
		.digram_ch (digram_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Cipher state as the block should hold it: key square, direction, waiting letter.
	row_t    key_rows [SIDE];
	dir_t    cur_dir;
	letter_t held_ltr;
	bit      held_ok;

	letter_beat_t letter_q [$];
	digram_t      owed_digrams [$];

	int beats_queued;
	int beats_in;
	int beats_taken;
	int mismatches;
	int cycles;

	// Sender and receiver idling controls.
	bit in_flight;
	bit no_idle;
	int gap_left;
	int quiet_left;
	int stall_left;
	int calm_left;
	int hold_left;
	int hold_seen;
	int hold_trigger;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Cipher prediction
	// ------------------------------------------------------------------

	function automatic letter_t square_cell(int r, int c);
		return key_rows[r][LW*c +: LW];
	endfunction

	// Scan row-major so the first copy of a duplicated letter wins; codes
	// above z never match, and neither does a cell holding j since inputs
	// fold j to i before the lookup.
	function automatic bit find_letter(letter_t l, output int r, output int c);
		r = 0;
		c = 0;
		if (l > LAST_LETTER)
			return 1'b0;
		for (int i = 0; i < SIDE * SIDE; i++) begin
			if (square_cell(i / SIDE, i % SIDE) == l) begin
				r = i / SIDE;
				c = i % SIDE;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Rewrite one digram: same row shifts columns, same column shifts rows,
	// anything else swaps columns across the rectangle.
	function automatic digram_t substitute(letter_t a, letter_t b);
		digram_t d;
		int      r1, c1, r2, c2, shift;
		d = '0;
		shift = (cur_dir == DIR_DEC) ? SIDE - 1 : 1;
		if (!find_letter(a, r1, c1) || !find_letter(b, r2, c2)) begin
			d.status = ST_NOT_FOUND;
			return d;
		end
		d.status = ST_OK;
		if (r1 == r2) begin
			d.first  = square_cell(r1, (c1 + shift) % SIDE);
			d.second = square_cell(r2, (c2 + shift) % SIDE);
		end else if (c1 == c2) begin
			d.first  = square_cell((r1 + shift) % SIDE, c1);
			d.second = square_cell((r2 + shift) % SIDE, c2);
		end else begin
			d.first  = square_cell(r1, c2);
			d.second = square_cell(r2, c1);
		end
		return d;
	endfunction

	// Advance the pairing state by one letter beat; returns 1 when a digram is due.
	function automatic bit next_digram(logic flush, letter_t raw, output digram_t d);
		letter_t l;
		l = (raw == LETTER_J) ? LETTER_I : raw;
		d = '0;
		if (flush) begin
			if (!held_ok)
				return 1'b0;
			held_ok = 1'b0;
			// Decrypt drops a lone trailing letter; encrypt pads it with z.
			if (cur_dir == DIR_DEC)
				d.status = ST_ODD;
			else
				d = substitute(held_ltr, LETTER_Z);
			held_ltr = '0;
			return 1'b1;
		end
		if (!held_ok) begin
			held_ltr = l;
			held_ok  = 1'b1;
			return 1'b0;
		end
		// Doubled letter while encrypting: split with x, keep the new copy waiting.
		if (cur_dir == DIR_ENC && l == held_ltr) begin
			d = substitute(held_ltr, LETTER_X);
			return 1'b1;
		end
		d = substitute(held_ltr, l);
		held_ok  = 1'b0;
		held_ltr = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic add_beat(logic flush, letter_t l);
		letter_q.push_back('{flush, l});
		beats_queued++;
	endtask

	// Mostly real letters, with doubled letters, flushes and codes past z mixed in.
	task automatic add_random(int n);
		int      pick;
		letter_t l;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			l = letter_t'($urandom_range(0, LAST_LETTER));
			if (pick < 10) begin
				add_beat(1'b1, letter_t'($urandom));
			end else if (pick < 15) begin
				add_beat(1'b0, letter_t'($urandom_range(LAST_LETTER + 1, 31)));
			end else if (pick < 30) begin
				add_beat(1'b0, l);
				add_beat(1'b0, l);
			end else begin
				add_beat(1'b0, l);
			end
		end
	endtask

	// Register write in two phases; the shadow copy changes at the access edge.
	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_DIR)
			cur_dir = dir_t'(value[0]);
		else
			key_rows[idx] = value[ROW_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Shuffle the 25 letters without j into a fresh key square.
	task automatic load_random_square();
		letter_t cells [SIDE*SIDE];
		letter_t t;
		row_t    rv;
		int      k, s;
		k = 0;
		for (int l = 0; l <= LAST_LETTER; l++) begin
			if (letter_t'(l) != LETTER_J) begin
				cells[k] = letter_t'(l);
				k++;
			end
		end
		for (int i = SIDE * SIDE - 1; i > 0; i--) begin
			s = $urandom_range(0, i);
			t = cells[i];
			cells[i] = cells[s];
			cells[s] = t;
		end
		for (int r = 0; r < SIDE; r++) begin
			rv = '0;
			for (int c = 0; c < SIDE; c++)
				rv[LW*c +: LW] = cells[r*SIDE + c];
			apb_write(reg_idx_t'(r), DATA_W'(rv));
		end
	endtask

	// Wait until every queued beat is taken and every digram has come back,
	// then let the pipeline run dry before touching registers.
	task automatic settle();
		while (beats_in != beats_queued || owed_digrams.size() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Letter driver: present beats from the queue, idle in random bursts
	// ------------------------------------------------------------------

	always @(negedge clk) begin : send_letters
		letter_beat_t beat;
		if (arst_n) begin
			// A beat taken at the last rising edge frees the channel.
			if (beats_in != beats_taken) begin
				beats_taken = beats_in;
				in_flight   = 1'b0;
			end
			if (!in_flight) begin
				if (gap_left > 0) begin
					gap_left--;
					letter_ch.valid <= 1'b0;
				end else if (letter_q.size() != 0) begin
					beat = letter_q.pop_front();
					letter_ch.valid  <= 1'b1;
					letter_ch.action <= beat.flush;
					letter_ch.letter <= beat.ltr;
					in_flight = 1'b1;
					// Schedule a gap after this beat, or a quiet stretch without one.
					if (!no_idle) begin
						if (quiet_left > 0)
							quiet_left--;
						else if ($urandom_range(0, 7) == 0)
							gap_left = $urandom_range(1, 19);
						else if ($urandom_range(0, 24) == 0)
							quiet_left = $urandom_range(20, 60);
					end
				end else begin
					letter_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Digram receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------

	always @(negedge clk) begin : take_digrams
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				digram_ch.ready <= 1'b0;
			end else if (hold_trigger != hold_seen) begin
				// Hold off long enough for the job queue to fill and stall letters.
				hold_seen = hold_trigger;
				hold_left = LONG_HOLD;
				digram_ch.ready <= 1'b0;
			end else if (no_idle) begin
				digram_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				digram_ch.ready <= 1'b0;
			end else begin
				digram_ch.ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 19);
				else if ($urandom_range(0, 19) == 0)
					calm_left = $urandom_range(20, 80);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on accepted letters, check accepted digrams
	// ------------------------------------------------------------------

	always @(posedge clk) begin : watch
		digram_t want;
		digram_t got;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: timeout after %0d cycles", $time, cycles);
				$display("Simulation FAILED");
				$finish;
			end else begin
				if (letter_ch.valid && letter_ch.ready) begin
					beats_in++;
					if (next_digram(letter_ch.action, letter_ch.letter, want))
						owed_digrams.push_back(want);
				end
				if (digram_ch.valid && digram_ch.ready) begin
					got.first  = digram_ch.out_first;
					got.second = digram_ch.out_second;
					got.status = digram_ch.status;
					if (owed_digrams.size() == 0) begin
						mismatches++;
						$display("%0t: unexpected digram first=%0d second=%0d status=%0d",
							$time, got.first, got.second, got.status);
					end else begin
						want = owed_digrams.pop_front();
						if (got.first !== want.first) begin
							mismatches++;
							$display("%0t: out_first expected %0d actual %0d",
								$time, want.first, got.first);
						end
						if (got.second !== want.second) begin
							mismatches++;
							$display("%0t: out_second expected %0d actual %0d",
								$time, want.second, got.second);
						end
						if (got.status !== want.status) begin
							mismatches++;
							$display("%0t: status expected %0d actual %0d",
								$time, want.status, got.status);
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		letter_ch.valid  = 1'b0;
		letter_ch.action = 1'b0;
		letter_ch.letter = '0;
		digram_ch.ready  = 1'b0;

		key_rows[0] = ROW0_RST;
		key_rows[1] = ROW1_RST;
		key_rows[2] = ROW2_RST;
		key_rows[3] = ROW3_RST;
		key_rows[4] = ROW4_RST;
		cur_dir     = DIR_ENC;
		held_ltr    = '0;
		held_ok     = 1'b0;

		beats_queued = 0;
		beats_in     = 0;
		beats_taken  = 0;
		mismatches   = 0;
		cycles       = 0;
		in_flight    = 1'b0;
		no_idle      = 1'b0;
		gap_left     = 0;
		quiet_left   = 0;
		stall_left   = 0;
		calm_left    = 0;
		hold_left    = 0;
		hold_seen    = 0;
		hold_trigger = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default square, encrypt: field extremes, j folding, doubled letters,
		// codes past z, padding and an empty flush.
		add_beat(1'b0, letter_t'(0));
		add_beat(1'b0, LAST_LETTER);
		add_beat(1'b0, LETTER_J);
		add_beat(1'b0, LETTER_I);
		add_beat(1'b0, letter_t'(31));
		add_beat(1'b0, letter_t'(4));
		add_beat(1'b1, letter_t'(0));
		add_beat(1'b1, letter_t'(31));
		add_beat(1'b0, LETTER_X);
		add_beat(1'b0, LETTER_X);
		add_beat(1'b0, letter_t'(26));
		add_beat(1'b0, LETTER_Z);
		add_beat(1'b0, LETTER_Z);
		add_beat(1'b1, letter_t'(0));
		add_random(80);
		// Leave a letter waiting across the switch to decrypt.
		add_beat(1'b0, letter_t'(7));
		settle();
		apb_write(REG_DIR, DATA_W'(DIR_DEC));

		// Decrypt: identical pair, odd trailing letter, j folding, miss, empty flush.
		add_beat(1'b0, letter_t'(7));
		add_beat(1'b0, letter_t'(3));
		add_beat(1'b1, letter_t'(0));
		add_beat(1'b0, LETTER_J);
		add_beat(1'b0, letter_t'(0));
		add_beat(1'b0, letter_t'(26));
		add_beat(1'b0, letter_t'(2));
		add_beat(1'b1, letter_t'(5));
		add_random(70);
		settle();

		// Odd square: a row of unused codes, a row of duplicate a's,
		// a row with j and a code past z in it.
		apb_write(REG_DIR, DATA_W'(DIR_ENC));
		apb_write(REG_ROW0, DATA_W'({ROW_W{1'b1}}));
		apb_write(REG_ROW1, '0);
		apb_write(REG_ROW2, DATA_W'({letter_t'(4), letter_t'(3), letter_t'(2),
			letter_t'(26), LETTER_J}));
		add_beat(1'b0, letter_t'(0));
		add_beat(1'b0, letter_t'(2));
		add_beat(1'b0, LETTER_J);
		add_beat(1'b0, letter_t'(3));
		add_random(40);
		settle();
		apb_write(REG_DIR, DATA_W'(DIR_DEC));
		add_beat(1'b0, letter_t'(0));
		add_beat(1'b0, letter_t'(0));
		add_random(30);
		settle();

		// Fresh square, encrypt, with a long receiver hold-off to back up the queue.
		load_random_square();
		apb_write(REG_DIR, DATA_W'(DIR_ENC));
		hold_trigger++;
		add_random(80);
		settle();

		// Fresh square, decrypt, full rate on both sides.
		load_random_square();
		apb_write(REG_DIR, DATA_W'(DIR_DEC));
		no_idle = 1'b1;
		add_random(60);
		settle();

		if (mismatches == 0 && owed_digrams.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
